// File: rtl/sm4_cipher_ecb_cbc_top_assert.svh
// ----------------------------------------------------------------------------
// SM4 cipher assertion macros
// Clocked property wrappers for the RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef SM4_CIPHER_ECB_CBC_TOP_ASSERT_SVH
`define SM4_CIPHER_ECB_CBC_TOP_ASSERT_SVH

// checked after reset is released
`define SM4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define SM4_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/sm4_pkg.sv
// ----------------------------------------------------------------------------
// SM4 package
// S-box, system constants, round control type and helper functions.
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int unsigned Rounds   = 32;
  localparam int unsigned RndIdxW  = $clog2(Rounds);

  typedef logic [31:0]        word_t;
  typedef logic [127:0]       blk_t;
  typedef logic [RndIdxW-1:0] rnd_idx_t;

  typedef struct packed {
    logic     key_mode;  // 1: key schedule round, 0: data round
    rnd_idx_t idx;       // round number, selects CK in key mode
  } rnd_ctl_t;

  localparam word_t FK0 = 32'hA3B1BAC6;
  localparam word_t FK1 = 32'h56AA3350;
  localparam word_t FK2 = 32'h677D9197;
  localparam word_t FK3 = 32'hB27022DC;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic word_t tau(input word_t v);
    word_t r;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = SBOX[v[8*b +: 8]];
    end
    return r;
  endfunction

  function automatic word_t rol(input word_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // CK byte j of word i is (4i+j)*7 mod 256, byte 0 in the top bits
  function automatic word_t ck_word(input rnd_idx_t i);
    word_t      w;
    logic [7:0] b;
    for (int j = 0; j < 4; j++) begin
      b = 8'({i, 2'(j)});
      w[8*(3-j) +: 8] = 8'(b * 8'd7);
    end
    return w;
  endfunction

endpackage

// File: rtl/sm4_round.sv
// ----------------------------------------------------------------------------
// SM4 round unit
// One round of either the key schedule or the data path: S-box layer,
// linear mix and feedback XOR. Shared by both phases.
// ----------------------------------------------------------------------------
module sm4_round (
  input  logic [127:0]      st_i,   // {w0, w1, w2, w3}
  input  logic [31:0]       rk_i,
  input  sm4_pkg::rnd_ctl_t ctl_i,
  output logic [31:0]       nw_o
);
  import sm4_pkg::*;

  word_t x;
  word_t b;
  word_t lin;

  always_comb begin
    x = st_i[95:64] ^ st_i[63:32] ^ st_i[31:0] ^ (ctl_i.key_mode ? ck_word(ctl_i.idx) : rk_i);
    b = tau(x);
    if (ctl_i.key_mode) begin
      lin = b ^ rol(b, 13) ^ rol(b, 23);
    end else begin
      lin = b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
    end
    nw_o = st_i[127:96] ^ lin;
  end

endmodule

// File: rtl/sm4_cipher_ecb_cbc_top.sv
// ----------------------------------------------------------------------------
// SM4 ECB/CBC cipher top level
// Register port, round key store, block sequencer and output register.
// ----------------------------------------------------------------------------
// One 128-bit block runs from acceptance back to ready through a setup state
// (StPrep), 32 rounds through the single shared round unit (one round per
// cycle, StRnd), and a finish state (StFin) that loads the output register once
// it is free and, in CBC mode, updates the chaining value. After a key register
// write the next block first runs the key schedule through the same round unit,
// 32 more rounds, and the round keys then stay valid until the key is written again.
// The finished block waits in the output register, so the next block can be
// taken meanwhile.
module sm4_cipher_ecb_cbc_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  // input beats
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // block_high, block_low
  input  logic         s_tuser,   // first_block
  // output beats
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // result_high, result_low
);
  import sm4_pkg::*;

  localparam logic [2:0] RegKeyHi = 3'd0;
  localparam logic [2:0] RegKeyLo = 3'd1;
  localparam logic [2:0] RegIvHi  = 3'd2;
  localparam logic [2:0] RegIvLo  = 3'd3;
  localparam logic [2:0] RegMode  = 3'd4;
  localparam logic [2:0] RegDir   = 3'd5;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StKey  = 3'd1;
  localparam logic [2:0] StPrep = 3'd2;
  localparam logic [2:0] StRnd  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  // configuration
  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic        cbc_q, dec_q;
  logic        keys_ready_q, keys_ready_d;
  logic        wr_en;
  logic [2:0]  reg_idx;

  // sequencer and data path
  logic [2:0]  state_q, state_d;
  rnd_idx_t    cnt_q, cnt_d;
  blk_t        st_q, st_d;
  blk_t        blk_q;
  blk_t        chain_q, chain_d;
  logic        first_q;
  logic        out_vld_q, out_vld_d;
  blk_t        out_q;
  logic        out_ld;
  blk_t        res;
  word_t       nw;
  rnd_ctl_t    ctl;
  logic        s_acc;

  // round keys
  word_t       rk_mem [Rounds];
  word_t       rk_q;
  rnd_idx_t    rk_raddr;
  logic        rk_we;

  // check helpers
  logic        key_last;
  logic        iv_load;
  blk_t        iv_cat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];

  always_comb begin
    unique case (reg_idx)
      RegKeyHi: prdata = key_hi_q;
      RegKeyLo: prdata = key_lo_q;
      RegIvHi:  prdata = iv_hi_q;
      RegIvLo:  prdata = iv_lo_q;
      RegMode:  prdata = {63'd0, cbc_q};
      RegDir:   prdata = {63'd0, dec_q};
      default:  prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q  <= '0;
      iv_lo_q  <= '0;
      cbc_q    <= 1'b0;
      dec_q    <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegKeyHi: key_hi_q <= pwdata;
        RegKeyLo: key_lo_q <= pwdata;
        RegIvHi:  iv_hi_q  <= pwdata;
        RegIvLo:  iv_lo_q  <= pwdata;
        RegMode:  cbc_q    <= pwdata[0];
        RegDir:   dec_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign s_tready = (state_q == StIdle);
  assign s_acc    = s_tvalid && s_tready;

  assign ctl = '{key_mode: (state_q == StKey), idx: cnt_q};

  sm4_round u_round (
    .st_i  (st_q),
    .rk_i  (rk_q),
    .ctl_i (ctl),
    .nw_o  (nw)
  );

  // output block is {w3, w2, w1, w0}
  always_comb begin
    res = {st_q[31:0], st_q[63:32], st_q[95:64], st_q[127:96]};
    if (cbc_q && dec_q) begin
      res = res ^ chain_q;
    end
  end

  assign out_ld = (state_q == StFin) && (!out_vld_q || m_tready);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    st_d         = st_q;
    chain_d      = chain_q;
    keys_ready_d = keys_ready_q;
    rk_we        = 1'b0;
    rk_raddr     = dec_q ? ~cnt_q : cnt_q;
    out_vld_d    = out_vld_q && !m_tready;

    if (wr_en && (reg_idx == RegKeyHi || reg_idx == RegKeyLo)) begin
      keys_ready_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_acc) begin
          cnt_d = '0;
          if (s_tuser) begin
            chain_d = {iv_hi_q, iv_lo_q};
          end
          if (keys_ready_q) begin
            state_d = StPrep;
          end else begin
            state_d = StKey;
            st_d    = {FK0 ^ key_hi_q[63:32], FK1 ^ key_hi_q[31:0],
                       FK2 ^ key_lo_q[63:32], FK3 ^ key_lo_q[31:0]};
          end
        end
      end
      StKey: begin
        rk_we = 1'b1;
        st_d  = {st_q[95:0], nw};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rnd_idx_t'(Rounds - 1)) begin
          keys_ready_d = 1'b1;
          state_d      = StPrep;
        end
      end
      StPrep: begin
        st_d    = (cbc_q && !dec_q) ? (blk_q ^ chain_q) : blk_q;
        state_d = StRnd;
      end
      StRnd: begin
        rk_raddr = dec_q ? ~(cnt_q + 1'b1) : (cnt_q + 1'b1);
        st_d     = {st_q[95:0], nw};
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == rnd_idx_t'(Rounds - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_ld) begin
          out_vld_d = 1'b1;
          state_d   = StIdle;
          if (cbc_q) begin
            chain_d = dec_q ? blk_q : res;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      chain_q      <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      keys_ready_q <= keys_ready_d;
      chain_q      <= chain_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (s_acc) begin
      blk_q   <= {s_tdata[63:0], s_tdata[127:64]};
      first_q <= s_tuser;
    end
    if (out_ld) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rk_we) begin
      rk_mem[cnt_q] <= nw;
    end
    rk_q <= rk_mem[rk_raddr];
  end

  assign m_tvalid = out_vld_q;
  assign m_tdata  = {out_q[63:0], out_q[127:64]};

  assign key_last = (state_q == StKey) && (cnt_q == rnd_idx_t'(Rounds - 1));
  assign iv_load  = s_acc && s_tuser;
  assign iv_cat   = {iv_hi_q, iv_lo_q};

`include "sm4_cipher_ecb_cbc_top_assert.svh"

  `SM4_ASSERT(a_acc_starts, s_acc |=> (state_q == StKey || state_q == StPrep), "block not started")
  `SM4_ASSERT(a_rnd_keys, (state_q == StRnd) |-> keys_ready_q, "data round with stale keys")
  `SM4_ASSERT(a_key_done, key_last |=> (state_q == StPrep && keys_ready_q), "key schedule stuck")
  `SM4_ASSERT(a_out_from_fin, $rose(m_tvalid) |-> $past(state_q) == StFin, "stray output beat")
  `SM4_ASSERT(a_first_chain, iv_load |=> (chain_q == $past(iv_cat) && first_q), "IV not reloaded")
  `SM4_ASSERT_ALWAYS(a_ready_idle, s_tready |-> (state_q != StRnd && state_q != StKey), "busy")

endmodule
